[hw/rtl/vrp_pkg.sv]
// Shared types, widths and trigonometry tables for the vertex rotate and project block.
package vrp_pkg;

    localparam int COORD_W   = 16;
    localparam int ANGLE_W   = 9;
    localparam int TRIG_W    = 10;
    localparam int TRIG_FRAC = 8;
    localparam int ROT_W     = 22;
    localparam int PROD_W    = 32;
    localparam int OUT_W     = 21;
    localparam int DIST_W    = 15;
    localparam int NUMS_W    = 38;
    localparam int DENS_W    = 24;
    localparam int NUM_W     = 37;
    localparam int DEN_W     = 23;
    localparam int SCREEN_W  = 32;
    localparam int IDX_W     = 8;
    localparam int CFG_W     = 16;

    localparam logic [IDX_W-1:0] REG_VIEW_DISTANCE = 8'd0;
    localparam logic [IDX_W-1:0] REG_DEPTH_OFFSET  = 8'd1;

    localparam logic [ANGLE_W-1:0] FULL_TURN    = 9'd360;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 9'd90;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 9'd180;
    localparam logic [ANGLE_W-1:0] THREE_QTR    = 9'd270;

    // Sine of 0 to 90 degrees scaled by 256, truncated.
    localparam logic [8:0] QUARTER_ROM [0:90] = '{
          0,   4,   8,  13,  17,  22,  26,  31,  35,  40,
         44,  48,  53,  57,  61,  66,  70,  74,  79,  83,
         87,  91,  95, 100, 104, 108, 112, 116, 120, 124,
        128, 131, 135, 139, 143, 146, 150, 154, 157, 161,
        164, 167, 171, 174, 177, 181, 184, 187, 190, 193,
        196, 198, 201, 204, 207, 209, 212, 214, 217, 219,
        221, 223, 226, 228, 230, 232, 233, 235, 237, 238,
        240, 242, 243, 244, 246, 247, 248, 249, 250, 251,
        252, 252, 253, 254, 254, 255, 255, 255, 255, 255,
        256
    };

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rem_h;
        logic [DEN_W-1:0]  rem_v;
        logic [NUM_W-1:0]  qn_h;
        logic [NUM_W-1:0]  qn_v;
        logic [DEN_W-1:0]  den;
        logic              neg_h;
        logic              neg_v;
        logic              err;
        logic [OUT_W-1:0]  px;
        logic [OUT_W-1:0]  py;
        logic [OUT_W-1:0]  pz;
    } div_stage_t;

    function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] a);
        return (a >= FULL_TURN) ? ANGLE_W'(a - FULL_TURN) : a;
    endfunction

    function automatic trig_t base_sin(input logic [ANGLE_W-1:0] a);
        logic [8:0] mag;
        logic       neg;
        neg = 1'b0;
        if (a < QUARTER_TURN) begin
            mag = QUARTER_ROM[7'(a)];
        end else if (a < HALF_TURN) begin
            mag = QUARTER_ROM[7'(HALF_TURN - a)];
        end else if (a < THREE_QTR) begin
            mag = QUARTER_ROM[7'(a - HALF_TURN)];
            neg = 1'b1;
        end else begin
            mag = QUARTER_ROM[7'(FULL_TURN - a)];
            neg = 1'b1;
        end
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // The table pi is slightly small, so a few exact points differ from symmetry.
    function automatic trig_t sin_q(input logic [ANGLE_W-1:0] a);
        trig_t r;
        case (a)
            9'd30:   r = 10'sd127;
            9'd90:   r = 10'sd255;
            9'd210:  r = -10'sd127;
            9'd270:  r = -10'sd255;
            default: r = base_sin(a);
        endcase
        return r;
    endfunction

    function automatic trig_t cos_q(input logic [ANGLE_W-1:0] a);
        trig_t r;
        case (a)
            9'd120:  r = -10'sd127;
            9'd180:  r = -10'sd255;
            9'd300:  r = 10'sd127;
            default: r = base_sin(wrap_angle(ANGLE_W'(a + QUARTER_TURN)));
        endcase
        return r;
    endfunction

    // One restoring division step for both quotients.
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t       o;
        logic [DEN_W:0]   th;
        logic [DEN_W:0]   tv;
        logic             gh;
        logic             gv;
        o  = s;
        th = {s.rem_h, s.qn_h[NUM_W-1]};
        tv = {s.rem_v, s.qn_v[NUM_W-1]};
        gh = th >= {1'b0, s.den};
        gv = tv >= {1'b0, s.den};
        o.rem_h = gh ? DEN_W'(th - {1'b0, s.den}) : th[DEN_W-1:0];
        o.rem_v = gv ? DEN_W'(tv - {1'b0, s.den}) : tv[DEN_W-1:0];
        o.qn_h  = {s.qn_h[NUM_W-2:0], gh};
        o.qn_v  = {s.qn_v[NUM_W-2:0], gv};
        return o;
    endfunction

    function automatic logic [SCREEN_W-1:0] sat_signed(input logic [NUM_W-1:0] q,
                                                       input logic neg);
        logic [SCREEN_W-1:0] r;
        if (neg) begin
            if (q > NUM_W'(64'h8000_0000)) r = 32'h8000_0000;
            else r = SCREEN_W'(-q);
        end else begin
            if (q > NUM_W'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
            else r = q[SCREEN_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/vertex_rotate_project_top.sv]
// Top level of the vertex rotate and project pipeline.
//
// Usage: each transaction on the s_ channel carries one vertex, a reference
// point and three whole-degree angles. The block rotates the vertex in three
// stages, adds the reference point and divides for the perspective view.
// Each transaction on the m_ channel carries the rotated point, the screen
// coordinates in tdata and the divide error flag in tuser.
// The cfg_ channel writes view distance (index 0) and depth offset (index 1)
// and is always ready; write it only while the pipeline is empty.
// One transaction is accepted every cycle while the receiver does not stall.
// The pipeline depth is set by the two restoring dividers, one quotient bit
// per stage, behind nine rotation and multiply stages.
// A low aresetn clears all valid bits and restores the default registers.
// When the receiver stalls, the whole pipeline holds and s_tready falls.
module vertex_rotate_project_top
    import vrp_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // vertex_x, vertex_y, vertex_z, ref_x, ref_y, ref_z, angle_first,
    // angle_second, angle_third, zero fill
    input  logic [127:0]   s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // rotated_x, rotated_y, rotated_z, screen_h, screen_v, zero fill
    output logic [127:0]   m_tdata,
    // divide_error
    output logic           m_tuser,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic                     adv;
    logic [DIST_W-1:0]        dist_reg;
    logic signed [CFG_W-1:0]  offset_reg;
    logic [9:0]               v_reg;

    // stage 0
    logic signed [ROT_W-1:0]   s0_x_reg, s0_y_reg, s0_z_reg;
    logic signed [COORD_W-1:0] s0_rx_reg, s0_ry_reg, s0_rz_reg;
    trig_t s0_ca_reg, s0_sa_reg, s0_cb_reg, s0_sb_reg, s0_ct_reg, s0_st_reg;
    // stage 1
    logic signed [PROD_W-1:0]  s1_p0_reg, s1_p1_reg, s1_p2_reg, s1_p3_reg;
    logic signed [ROT_W-1:0]   s1_z_reg;
    logic signed [COORD_W-1:0] s1_rx_reg, s1_ry_reg, s1_rz_reg;
    trig_t s1_cb_reg, s1_sb_reg, s1_ct_reg, s1_st_reg;
    // stage 2
    logic signed [ROT_W-1:0]   s2_x1_reg, s2_y1_reg, s2_z_reg;
    logic signed [COORD_W-1:0] s2_rx_reg, s2_ry_reg, s2_rz_reg;
    trig_t s2_cb_reg, s2_sb_reg, s2_ct_reg, s2_st_reg;
    // stage 3
    logic signed [PROD_W-1:0]  s3_p0_reg, s3_p1_reg, s3_p2_reg, s3_p3_reg;
    logic signed [ROT_W-1:0]   s3_y1_reg;
    logic signed [COORD_W-1:0] s3_rx_reg, s3_ry_reg, s3_rz_reg;
    trig_t s3_ct_reg, s3_st_reg;
    // stage 4
    logic signed [ROT_W-1:0]   s4_x2_reg, s4_z1_reg, s4_y1_reg;
    logic signed [COORD_W-1:0] s4_rx_reg, s4_ry_reg, s4_rz_reg;
    trig_t s4_ct_reg, s4_st_reg;
    // stage 5
    logic signed [PROD_W-1:0]  s5_p0_reg, s5_p1_reg, s5_p2_reg, s5_p3_reg;
    logic signed [ROT_W-1:0]   s5_x2_reg;
    logic signed [COORD_W-1:0] s5_rx_reg, s5_ry_reg, s5_rz_reg;
    // stage 6
    logic signed [ROT_W-1:0]   s6_x2_reg, s6_y2_reg, s6_z2_reg;
    logic signed [COORD_W-1:0] s6_rx_reg, s6_ry_reg, s6_rz_reg;
    // stage 7
    logic signed [ROT_W-1:0]   s7_px_reg, s7_py_reg, s7_pz_reg;
    // stage 8
    logic signed [NUMS_W-1:0]  s8_nh_reg, s8_nv_reg;
    logic signed [DENS_W-1:0]  s8_den_reg;
    logic [OUT_W-1:0]          s8_px_reg, s8_py_reg, s8_pz_reg;
    // divider
    div_stage_t                div_reg [0:NUM_W];
    logic [NUM_W-1:0]          dv_reg;
    div_stage_t                div_next;
    // output
    logic                      m_tvalid_reg;
    logic [127:0]              m_tdata_reg;
    logic                      m_tuser_reg;

    logic [ANGLE_W-1:0] ang_a, ang_b, ang_t;
    logic signed [ROT_W-1:0] dist_s;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign ang_a  = wrap_angle(s_tdata[104:96]);
    assign ang_b  = wrap_angle(s_tdata[113:105]);
    assign ang_t  = wrap_angle(s_tdata[122:114]);
    assign dist_s = ROT_W'($signed({1'b0, dist_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg   <= DIST_W'(256);
            offset_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_VIEW_DISTANCE) begin
                dist_reg <= cfg_data[DIST_W-1:0];
            end else if (cfg_index == REG_DEPTH_OFFSET) begin
                offset_reg <= $signed(cfg_data);
            end
        end
    end

    // Bit i of dv_reg marks a valid transaction in divider stage i + 1.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            dv_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v_reg        <= {v_reg[8:0], s_tvalid};
            dv_reg       <= {dv_reg[NUM_W-2:0], v_reg[9]};
            m_tvalid_reg <= dv_reg[NUM_W-1];
        end
    end

    // Absolute values for the dividers.
    always_comb begin
        div_next.rem_h = '0;
        div_next.rem_v = '0;
        div_next.qn_h  = s8_nh_reg[NUMS_W-1] ? NUM_W'(-s8_nh_reg) : NUM_W'(s8_nh_reg);
        div_next.qn_v  = s8_nv_reg[NUMS_W-1] ? NUM_W'(-s8_nv_reg) : NUM_W'(s8_nv_reg);
        div_next.den   = s8_den_reg[DENS_W-1] ? DEN_W'(-s8_den_reg) : DEN_W'(s8_den_reg);
        div_next.neg_h = s8_nh_reg[NUMS_W-1] ^ s8_den_reg[DENS_W-1];
        div_next.neg_v = s8_nv_reg[NUMS_W-1] ^ s8_den_reg[DENS_W-1];
        div_next.err   = (s8_den_reg == '0);
        div_next.px    = s8_px_reg;
        div_next.py    = s8_py_reg;
        div_next.pz    = s8_pz_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_x_reg  <= ROT_W'($signed(s_tdata[15:0]));
            s0_y_reg  <= ROT_W'($signed(s_tdata[31:16]));
            s0_z_reg  <= ROT_W'($signed(s_tdata[47:32]));
            s0_rx_reg <= $signed(s_tdata[63:48]);
            s0_ry_reg <= $signed(s_tdata[79:64]);
            s0_rz_reg <= $signed(s_tdata[95:80]);
            s0_ca_reg <= cos_q(ang_a);
            s0_sa_reg <= sin_q(ang_a);
            s0_cb_reg <= cos_q(ang_b);
            s0_sb_reg <= sin_q(ang_b);
            s0_ct_reg <= cos_q(ang_t);
            s0_st_reg <= sin_q(ang_t);

            s1_p0_reg <= PROD_W'(s0_x_reg * s0_ca_reg);
            s1_p1_reg <= PROD_W'(s0_y_reg * s0_sa_reg);
            s1_p2_reg <= PROD_W'(s0_y_reg * s0_ca_reg);
            s1_p3_reg <= PROD_W'(s0_x_reg * s0_sa_reg);
            s1_z_reg  <= s0_z_reg;
            s1_rx_reg <= s0_rx_reg;
            s1_ry_reg <= s0_ry_reg;
            s1_rz_reg <= s0_rz_reg;
            s1_cb_reg <= s0_cb_reg;
            s1_sb_reg <= s0_sb_reg;
            s1_ct_reg <= s0_ct_reg;
            s1_st_reg <= s0_st_reg;

            s2_x1_reg <= ROT_W'((s1_p0_reg >>> TRIG_FRAC) - (s1_p1_reg >>> TRIG_FRAC));
            s2_y1_reg <= ROT_W'((s1_p2_reg >>> TRIG_FRAC) + (s1_p3_reg >>> TRIG_FRAC));
            s2_z_reg  <= s1_z_reg;
            s2_rx_reg <= s1_rx_reg;
            s2_ry_reg <= s1_ry_reg;
            s2_rz_reg <= s1_rz_reg;
            s2_cb_reg <= s1_cb_reg;
            s2_sb_reg <= s1_sb_reg;
            s2_ct_reg <= s1_ct_reg;
            s2_st_reg <= s1_st_reg;

            s3_p0_reg <= PROD_W'(s2_x1_reg * s2_cb_reg);
            s3_p1_reg <= PROD_W'(s2_z_reg * s2_sb_reg);
            s3_p2_reg <= PROD_W'(s2_z_reg * s2_cb_reg);
            s3_p3_reg <= PROD_W'(s2_x1_reg * s2_sb_reg);
            s3_y1_reg <= s2_y1_reg;
            s3_rx_reg <= s2_rx_reg;
            s3_ry_reg <= s2_ry_reg;
            s3_rz_reg <= s2_rz_reg;
            s3_ct_reg <= s2_ct_reg;
            s3_st_reg <= s2_st_reg;

            s4_x2_reg <= ROT_W'((s3_p0_reg >>> TRIG_FRAC) - (s3_p1_reg >>> TRIG_FRAC));
            s4_z1_reg <= ROT_W'((s3_p2_reg >>> TRIG_FRAC) + (s3_p3_reg >>> TRIG_FRAC));
            s4_y1_reg <= s3_y1_reg;
            s4_rx_reg <= s3_rx_reg;
            s4_ry_reg <= s3_ry_reg;
            s4_rz_reg <= s3_rz_reg;
            s4_ct_reg <= s3_ct_reg;
            s4_st_reg <= s3_st_reg;

            s5_p0_reg <= PROD_W'(s4_z1_reg * s4_ct_reg);
            s5_p1_reg <= PROD_W'(s4_y1_reg * s4_st_reg);
            s5_p2_reg <= PROD_W'(s4_y1_reg * s4_ct_reg);
            s5_p3_reg <= PROD_W'(s4_z1_reg * s4_st_reg);
            s5_x2_reg <= s4_x2_reg;
            s5_rx_reg <= s4_rx_reg;
            s5_ry_reg <= s4_ry_reg;
            s5_rz_reg <= s4_rz_reg;

            s6_z2_reg <= ROT_W'((s5_p0_reg >>> TRIG_FRAC) - (s5_p1_reg >>> TRIG_FRAC));
            s6_y2_reg <= ROT_W'((s5_p2_reg >>> TRIG_FRAC) + (s5_p3_reg >>> TRIG_FRAC));
            s6_x2_reg <= s5_x2_reg;
            s6_rx_reg <= s5_rx_reg;
            s6_ry_reg <= s5_ry_reg;
            s6_rz_reg <= s5_rz_reg;

            s7_px_reg <= s6_x2_reg + ROT_W'(s6_rx_reg);
            s7_py_reg <= s6_y2_reg + ROT_W'(s6_ry_reg);
            s7_pz_reg <= s6_z2_reg + ROT_W'(s6_rz_reg);

            s8_nh_reg  <= NUMS_W'(s7_px_reg * dist_s);
            s8_nv_reg  <= NUMS_W'(s7_py_reg * dist_s);
            s8_den_reg <= DENS_W'(s7_pz_reg) + DENS_W'(dist_s) + DENS_W'(offset_reg);
            s8_px_reg  <= s7_px_reg[OUT_W-1:0];
            s8_py_reg  <= s7_py_reg[OUT_W-1:0];
            s8_pz_reg  <= s7_pz_reg[OUT_W-1:0];

            div_reg[0] <= div_next;
            for (int i = 0; i < NUM_W; i++) begin
                div_reg[i+1] <= div_step(div_reg[i]);
            end

            m_tdata_reg[20:0]    <= div_reg[NUM_W].px;
            m_tdata_reg[41:21]   <= div_reg[NUM_W].py;
            m_tdata_reg[62:42]   <= div_reg[NUM_W].pz;
            m_tdata_reg[94:63]   <= div_reg[NUM_W].err ? '0 :
                                    sat_signed(div_reg[NUM_W].qn_h, div_reg[NUM_W].neg_h);
            m_tdata_reg[126:95]  <= div_reg[NUM_W].err ? '0 :
                                    sat_signed(div_reg[NUM_W].qn_v, div_reg[NUM_W].neg_v);
            m_tdata_reg[127]     <= 1'b0;
            m_tuser_reg          <= div_reg[NUM_W].err;
        end
    end

endmodule
